// ===== hw/rtl/qsort_pkg.sv =====
// Shared constants, types and controller/datapath interface for the quicksort block.
package qsort_pkg;

    localparam int MAX_ITEMS   = 1024;
    localparam int ADDR_W      = $clog2(MAX_ITEMS);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int STACK_DEPTH = ADDR_W + 1;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int VAL_W       = 32;
    localparam int IDX_W       = 10;
    localparam int IN_DATA_W   = ((VAL_W + IDX_W + 7) / 8) * 8;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] base;
        logic [CNT_W-1:0] len;
    } t_span;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH_WAIT,
        S_SORT_INIT,
        S_POP,
        S_CHECK,
        S_RD_PIVOT,
        S_RD_HELD,
        S_CAP_HELD,
        S_LOOP
    } t_state;

    typedef struct packed {
        logic load;
        logic fetch;
        logic fetch_wait;
        logic sort_init;
        logic pop;
        logic rd_pivot;
        logic rd_held;
        logic cap_held;
        logic step;
        logic finish;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic            sp_zero;
        logic            len_ge2;
        logic            loop_go;
        logic            out_free;
        logic [SP_W-1:0] sp;
    } t_sts;

endpackage

// ===== hw/rtl/qsort_ctrl.sv =====
// Controller state machine: load/fetch handling and quicksort sequencing.
module qsort_ctrl import qsort_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_action,
    input  logic i_last,
    input  t_sts i_sts,
    output logic o_ready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_action == ACT_FETCH) begin
                        n_state = S_FETCH_WAIT;
                    end else if (i_last) begin
                        n_state = S_SORT_INIT;
                    end
                end
            end
            S_FETCH_WAIT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SORT_INIT: n_state = S_POP;
            S_POP: begin
                n_state = i_sts.sp_zero ? S_IDLE : S_CHECK;
            end
            S_CHECK: begin
                n_state = i_sts.len_ge2 ? S_RD_PIVOT : S_POP;
            end
            S_RD_PIVOT: n_state = S_RD_HELD;
            S_RD_HELD:  n_state = S_CAP_HELD;
            S_CAP_HELD: n_state = S_LOOP;
            S_LOOP: begin
                // step loops back through the held capture; a finished split re-checks
                n_state = i_sts.loop_go ? S_CAP_HELD : S_CHECK;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready       = 1'b1;
                o_cmd.load    = i_valid && (i_action == ACT_LOAD);
                o_cmd.fetch   = i_valid && (i_action == ACT_FETCH);
            end
            S_FETCH_WAIT: begin
                // keep the fetched entry on the read port until the result moves out
                o_cmd.fetch_wait = 1'b1;
                o_cmd.out_load   = i_sts.out_free;
            end
            S_SORT_INIT:  o_cmd.sort_init = 1'b1;
            S_POP:        o_cmd.pop       = !i_sts.sp_zero;
            S_CHECK:      o_cmd           = '0;
            S_RD_PIVOT:   o_cmd.rd_pivot  = 1'b1;
            S_RD_HELD:    o_cmd.rd_held   = 1'b1;
            S_CAP_HELD:   o_cmd.cap_held  = 1'b1;
            S_LOOP: begin
                o_cmd.step   = i_sts.loop_go;
                o_cmd.finish = !i_sts.loop_go;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== hw/rtl/qsort_dpath.sv =====
// Datapath: value store, range stack, partition registers and output register.
module qsort_dpath import qsort_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_last,
    input  logic [IDX_W-1:0]        i_index,
    input  logic                    i_out_ready,
    output t_sts                    o_sts,
    output logic                    o_out_valid,
    output logic signed [VAL_W-1:0] o_out_value,
    output logic                    o_out_oor
);

    logic signed [VAL_W-1:0] mem [MAX_ITEMS];
    logic signed [VAL_W-1:0] r_rdata;

    logic [CNT_W-1:0]        r_count;
    logic                    r_closed;
    logic [SP_W-1:0]         r_sp;
    t_span                   r_stack [STACK_DEPTH];
    logic [CNT_W-1:0]        r_base;
    logic [CNT_W-1:0]        r_len;
    logic [CNT_W-1:0]        r_lo;
    logic [CNT_W-1:0]        r_hi;
    logic signed [VAL_W-1:0] r_pivot;
    logic signed [VAL_W-1:0] r_held;
    logic                    r_oor;
    logic [ADDR_W-1:0]       r_fetch_addr;
    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_value;
    logic                    r_out_oor;

    logic [CNT_W-1:0]        load_pos;
    logic                    load_room;
    logic                    held_lt;
    logic [CNT_W-1:0]        part_f;
    logic [CNT_W-1:0]        right_base;
    logic [CNT_W-1:0]        right_len;
    logic                    left_first;
    logic [SP_W-1:0]         top_idx;
    t_span                   top_span;

    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic signed [VAL_W-1:0] wr_data;
    logic [ADDR_W-1:0]       rd_addr;
    logic [CNT_W-1:0]        hole_pos;
    logic [CNT_W-1:0]        next_lo_pos;
    logic [CNT_W-1:0]        hi_pos;
    logic [CNT_W-1:0]        held_pos;

    logic                    push_req;
    logic [SP_W-1:0]         push_idx;
    t_span                   push_span;
    logic                    push_ok;

    assign load_pos    = r_closed ? '0 : r_count;
    assign load_room   = load_pos < CNT_W'(MAX_ITEMS);
    assign held_lt     = r_held < r_pivot;
    assign part_f      = r_lo - CNT_W'(1);
    assign right_base  = r_base + r_lo;
    assign right_len   = r_len - r_lo;
    assign left_first  = part_f <= right_len;
    assign top_idx     = r_sp - SP_W'(1);
    assign top_span    = r_stack[top_idx];

    assign hole_pos    = r_base + r_lo - CNT_W'(1);
    assign next_lo_pos = r_base + r_lo + CNT_W'(1);
    assign hi_pos      = r_base + r_hi;
    assign held_pos    = r_base + CNT_W'(1);

    // store port selection
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = hole_pos[ADDR_W-1:0];
        wr_data = r_held;
        rd_addr = r_base[ADDR_W-1:0];
        if (i_cmd.load) begin
            wr_en   = load_room;
            wr_addr = load_pos[ADDR_W-1:0];
            wr_data = i_value;
        end
        if (i_cmd.fetch) begin
            rd_addr = ADDR_W'(i_index);
        end
        if (i_cmd.fetch_wait) begin
            rd_addr = r_fetch_addr;
        end
        if (i_cmd.rd_pivot) begin
            rd_addr = r_base[ADDR_W-1:0];
        end
        if (i_cmd.rd_held) begin
            rd_addr = held_pos[ADDR_W-1:0];
        end
        if (i_cmd.step) begin
            wr_en = 1'b1;
            if (held_lt) begin
                wr_addr = hole_pos[ADDR_W-1:0];
                rd_addr = next_lo_pos[ADDR_W-1:0];
            end else begin
                // read-before-write on the same entry returns the old element
                wr_addr = hi_pos[ADDR_W-1:0];
                rd_addr = hi_pos[ADDR_W-1:0];
            end
        end
        if (i_cmd.finish) begin
            wr_en   = 1'b1;
            wr_addr = hole_pos[ADDR_W-1:0];
            wr_data = r_pivot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    // stack push: all items at start, then the larger part; the smaller continues
    always_comb begin
        push_req  = 1'b0;
        push_idx  = r_sp;
        push_span = '{base: right_base, len: right_len};
        if (i_cmd.sort_init) begin
            push_req  = r_count > CNT_W'(1);
            push_idx  = '0;
            push_span = '{base: '0, len: r_count};
        end else if (i_cmd.finish) begin
            if (left_first) begin
                push_req  = right_len > CNT_W'(1);
                push_span = '{base: right_base, len: right_len};
            end else begin
                push_req  = part_f > CNT_W'(1);
                push_span = '{base: r_base, len: part_f};
            end
        end
    end

    assign push_ok = push_req && (push_idx < SP_W'(STACK_DEPTH));

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_stack[push_idx] <= push_span;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_closed    <= 1'b0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_count  <= load_room ? load_pos + CNT_W'(1) : load_pos;
                r_closed <= i_last;
            end
            if (i_cmd.sort_init) begin
                r_sp <= push_ok ? SP_W'(1) : '0;
            end else if (i_cmd.pop) begin
                r_sp <= top_idx;
            end else if (push_ok) begin
                r_sp <= r_sp + SP_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch) begin
            r_oor        <= !(CNT_W'(i_index) < r_count);
            r_fetch_addr <= ADDR_W'(i_index);
        end
        if (i_cmd.out_load) begin
            r_out_value <= r_oor ? '0 : r_rdata;
            r_out_oor   <= r_oor;
        end
        if (i_cmd.pop) begin
            r_base <= top_span.base;
            r_len  <= top_span.len;
        end
        if (i_cmd.rd_held) begin
            r_pivot <= r_rdata;
            r_lo    <= CNT_W'(1);
            r_hi    <= r_len - CNT_W'(1);
        end
        if (i_cmd.cap_held) begin
            r_held <= r_rdata;
        end
        if (i_cmd.step) begin
            if (held_lt) begin
                r_lo <= r_lo + CNT_W'(1);
            end else begin
                r_hi <= r_hi - CNT_W'(1);
            end
        end
        if (i_cmd.finish) begin
            if (left_first) begin
                r_len <= part_f;
            end else begin
                r_base <= right_base;
                r_len  <= right_len;
            end
        end
    end

    assign o_sts.sp_zero  = (r_sp == '0);
    assign o_sts.len_ge2  = (r_len >= CNT_W'(2));
    assign o_sts.loop_go  = (r_lo <= r_hi);
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.sp       = r_sp;

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_out_oor   = r_out_oor;

endmodule

// ===== hw/rtl/quicksort_in_place_sorter_top.sv =====
// Top level of the in-place quicksort block: stream ports, controller and datapath.
//
//  channel   direction  tdata (low bit up)                 tlast        tuser
//  s_axis    in         value[31:0], index[41:32], zeros   last_of_set  action
//  m_axis    out        sorted_value[31:0]                 -            out_of_range
//
// A load writes the store while idle. A fetch reads the store, then loads the output register;
// it stays in the second step while the output register holds an unaccepted result.
// The load marked last runs the sort: a split reads the pivot and captures the held element,
// then alternates capture and step, since the store has registered read data; each popped
// range also passes through pop and check.
// s_axis_tready is low during the sort and while a fetch waits for the output register.
// Reset is synchronous, active low; the store holds no reset value.
module quicksort_in_place_sorter_top import qsort_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,   // value[31:0], index[41:32]
    input  logic                 s_axis_tlast,   // last_of_set
    input  logic                 s_axis_tuser,   // action
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [VAL_W-1:0]     m_axis_tdata,   // sorted_value[31:0]
    output logic                 m_axis_tuser    // out_of_range
);

    t_cmd                    cmd;
    t_sts                    sts;
    logic signed [VAL_W-1:0] out_value;

    qsort_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_action (s_axis_tuser),
        .i_last   (s_axis_tlast),
        .i_sts    (sts),
        .o_ready  (s_axis_tready),
        .o_cmd    (cmd)
    );

    qsort_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (s_axis_tdata[VAL_W-1:0]),
        .i_last      (s_axis_tlast),
        .i_index     (s_axis_tdata[VAL_W+IDX_W-1:VAL_W]),
        .i_out_ready (m_axis_tready),
        .o_sts       (sts),
        .o_out_valid (m_axis_tvalid),
        .o_out_value (out_value),
        .o_out_oor   (m_axis_tuser)
    );

    assign m_axis_tdata = out_value;

    // stack is empty whenever a new request can be taken
    a_idle_stack_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> sts.sp_zero)
        else $error("range stack not empty while idle");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.sp <= SP_W'(STACK_DEPTH))
        else $error("range stack pointer beyond depth");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("out-of-range result carries nonzero value");

    a_fetch_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_FETCH)) |=> !s_axis_tready)
        else $error("fetch did not hold off the next request");

endmodule
